[src/bht_pkg.sv]
// Shared types and constants of the bucketed hash table.
`default_nettype none
package bht_pkg;

   localparam int CHAR_W     = 8;
   localparam int KEY_CHARS  = 8;
   localparam int HASH_CHARS = 6;
   localparam int SLOTS      = 3;
   localparam int KEY_W      = 64;
   localparam int LEN_W      = 4;
   localparam int DATA_W     = 32;
   localparam int CFG_W      = 9;
   localparam int IDX_W      = 8;
   localparam int SLOT_W     = 2;
   localparam int CNT_W      = 16;
   localparam int BUCKET_COUNT_RESET = 256;

   localparam int SUM_W      = 11;
   localparam int MOD_STEPS  = 6;
   localparam int MOD_CYCLES = (SUM_W + MOD_STEPS - 1) / MOD_STEPS;
   localparam int STEP_W     = 1;
   localparam int DSH_W      = CFG_W + SUM_W - 1;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_MISS = 1'b1;

   typedef enum logic [1:0] {
      REQ_ADD    = 2'd0,
      REQ_SEARCH = 2'd1,
      REQ_REMOVE = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_WB
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [LEN_W-1:0]  len;
      logic [DATA_W-1:0] data;
   } slot_type;

   typedef struct packed {
      logic [SLOTS-1:0]           valid;
      slot_type [SLOTS-1:0]       slot;
   } row_type;

   typedef struct packed {
      logic             done;
      logic [SUM_W-1:0] remainder;
   } hash_rsp_type;

endpackage
`default_nettype wire

[src/bht_hash_unit.sv]
// Additive key hash followed by an iterative remainder by the bucket count.
`default_nettype none
module bht_hash_unit (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [bht_pkg::KEY_W-1:0] key,
   input  wire logic [bht_pkg::CFG_W-1:0] divisor,
   output bht_pkg::hash_rsp_type          hash_rsp
);
   import bht_pkg::*;

   logic [SUM_W-1:0]  sum;
   logic [SUM_W-1:0]  rem_ff, rem_in;
   logic [DSH_W-1:0]  dsh_ff, dsh_in;
   logic [DSH_W-1:0]  work_r, work_d;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;

   always_comb begin
      sum = '0;
      for (int i = 0; i < HASH_CHARS; i++) begin
         sum = sum + SUM_W'(key[i*CHAR_W +: CHAR_W]);
      end
   end

   always_comb begin
      work_r = DSH_W'(rem_ff);
      work_d = dsh_ff;
      for (int i = 0; i < MOD_STEPS; i++) begin
         if (int'(step_ff) * MOD_STEPS + i < SUM_W) begin
            if (work_r >= work_d) begin
               work_r = work_r - work_d;
            end
            work_d = work_d >> 1;
         end
      end
   end

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = sum;
         dsh_in  = DSH_W'(divisor) << (SUM_W - 1);
         step_in = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         rem_in  = work_r[SUM_W-1:0];
         dsh_in  = work_d;
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(MOD_CYCLES - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      if (reset) begin
         step_ff <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign hash_rsp.done      = done_ff;
   assign hash_rsp.remainder = rem_ff;

endmodule
`default_nettype wire

[src/bucketed_hash_table_unit.sv]
// Top level of the bucketed hash table with three slots per bucket.
`default_nettype none
// A request is taken when start is high and busy is low. Its result appears on
// the rsp_ ports for one cycle with rsp_valid high, once the request has gone
// through its steps: the key sum and its remainder by the bucket count in the
// iterative hash unit, the bucket memory read, and the write-back of the bucket
// row, from which the result is registered. A new request can be taken while the
// previous one is in write-back. After reset and after every write of
// csr_bucket_count the table runs a clearing pass through all BUCKETS rows of
// the bucket memory, with busy high. The receiver cannot stall results.
module bucketed_hash_table_unit #(
   parameter int BUCKETS = 256
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [1:0]                 req_type,
   input  wire logic [bht_pkg::KEY_W-1:0]  req_key_chars,
   input  wire logic [bht_pkg::LEN_W-1:0]  req_key_length,
   input  wire logic [bht_pkg::DATA_W-1:0] req_entry_data,
   output logic                            rsp_valid,
   output logic                            rsp_status,
   output logic [bht_pkg::DATA_W-1:0]      rsp_found_data,
   output logic [bht_pkg::IDX_W-1:0]       rsp_bucket_index,
   output logic [bht_pkg::SLOT_W-1:0]      rsp_slot_number,
   output logic [bht_pkg::CNT_W-1:0]       rsp_used_buckets,
   output logic [bht_pkg::CNT_W-1:0]       rsp_collision_count,
   output logic [bht_pkg::CNT_W-1:0]       rsp_full_bucket_count,
   output logic [bht_pkg::CFG_W-1:0]       rsp_empty_bucket_count,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [bht_pkg::CFG_W-1:0]  csr_bucket_count
);
   import bht_pkg::*;

   localparam int AW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

   function automatic logic [CFG_W-1:0] eff_of(input logic [CFG_W-1:0] bc);
      logic [CFG_W-1:0] n;
      n = (bc == '0) ? CFG_W'(1) : bc;
      if (int'(n) > BUCKETS) begin
         n = CFG_W'(BUCKETS);
      end
      return n;
   endfunction

   state_type          state_ff, state_in;
   logic [1:0]         kind_ff, kind_in;
   logic [KEY_W-1:0]   key_ff, key_in, key_m;
   logic [LEN_W-1:0]   len_ff, len_in, len_c;
   logic [DATA_W-1:0]  data_ff, data_in;
   logic [CFG_W-1:0]   eff_ff, eff_in;
   logic [CNT_W-1:0]   used_ff, used_in;
   logic [CNT_W-1:0]   coll_ff, coll_in;
   logic [CNT_W-1:0]   full_ff, full_in;
   logic [CFG_W-1:0]   free_ff, free_in;
   logic [AW-1:0]      clr_addr_ff, clr_addr_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]  rsp_found_ff, rsp_found_in;
   logic [IDX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic [SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;

   row_type            mem [BUCKETS];
   row_type            rd_row_ff;
   row_type            wr_row;
   logic               rd_en, wr_en;
   logic [AW-1:0]      rd_addr, wr_addr;

   logic               accept;
   hash_rsp_type       hash_rsp;

   logic [SLOTS-1:0]   match;
   logic               add_ok, hit;
   logic [SLOT_W-1:0]  add_slot, hit_slot;

   assign accept    = start && !busy;
   assign busy      = !(state_ff == ST_IDLE || state_ff == ST_WB);
   assign csr_ready = 1'b1;

   always_comb begin
      len_c = (req_key_length > LEN_W'(KEY_CHARS)) ? LEN_W'(KEY_CHARS) : req_key_length;
      key_m = '0;
      for (int i = 0; i < KEY_CHARS; i++) begin
         if (LEN_W'(i) < len_c) begin
            key_m[i*CHAR_W +: CHAR_W] = req_key_chars[i*CHAR_W +: CHAR_W];
         end
      end
   end

   bht_hash_unit u_hash (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .key      (key_m),
      .divisor  (eff_ff),
      .hash_rsp (hash_rsp)
   );

   always_comb begin
      add_ok   = 1'b0;
      add_slot = '0;
      hit      = 1'b0;
      hit_slot = '0;
      for (int s = 0; s < SLOTS; s++) begin
         match[s] = rd_row_ff.valid[s] && rd_row_ff.slot[s].len == len_ff &&
                    rd_row_ff.slot[s].key == key_ff;
      end
      for (int s = SLOTS - 1; s >= 0; s--) begin
         if (!rd_row_ff.valid[s]) begin
            add_ok   = 1'b1;
            add_slot = SLOT_W'(s);
         end
         if (match[s]) begin
            hit      = 1'b1;
            hit_slot = SLOT_W'(s);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      key_in       = key_ff;
      len_in       = len_ff;
      data_in      = data_ff;
      eff_in       = eff_ff;
      used_in      = used_ff;
      coll_in      = coll_ff;
      full_in      = full_ff;
      free_in      = free_ff;
      clr_addr_in  = clr_addr_ff;
      rsp_valid_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_found_in = rsp_found_ff;
      rsp_index_in = rsp_index_ff;
      rsp_slot_in  = rsp_slot_ff;
      rd_en        = 1'b0;
      rd_addr      = AW'(hash_rsp.remainder);
      wr_en        = 1'b0;
      wr_addr      = AW'(hash_rsp.remainder);
      wr_row       = rd_row_ff;

      if (accept) begin
         kind_in = req_type;
         key_in  = key_m;
         len_in  = len_c;
         data_in = req_entry_data;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_row      = '0;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(BUCKETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            if (hash_rsp.done) begin
               rd_en    = 1'b1;
               state_in = ST_WB;
            end
         end
         ST_WB: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_MISS;
            rsp_found_in  = '0;
            rsp_index_in  = hash_rsp.remainder[IDX_W-1:0];
            rsp_slot_in   = '0;
            if (kind_ff == REQ_ADD) begin
               if (add_ok) begin
                  rsp_status_in = STATUS_OK;
                  rsp_slot_in   = add_slot;
                  wr_en         = 1'b1;
                  wr_row.valid[add_slot]     = 1'b1;
                  wr_row.slot[add_slot].key  = key_ff;
                  wr_row.slot[add_slot].len  = len_ff;
                  wr_row.slot[add_slot].data = data_ff;
                  if (!rd_row_ff.valid[0]) begin
                     if (used_ff != '1) begin
                        used_in = used_ff + CNT_W'(1);
                     end
                     if (free_ff != '0) begin
                        free_in = free_ff - CFG_W'(1);
                     end
                  end
                  if (add_slot != '0 && coll_ff != '1) begin
                     coll_in = coll_ff + CNT_W'(1);
                  end
                  if (add_slot == SLOT_W'(SLOTS - 1) && full_ff != '1) begin
                     full_in = full_ff + CNT_W'(1);
                  end
               end
            end else if (kind_ff == REQ_SEARCH || kind_ff == REQ_REMOVE) begin
               if (hit) begin
                  rsp_status_in = STATUS_OK;
                  rsp_slot_in   = hit_slot;
                  if (kind_ff == REQ_SEARCH) begin
                     rsp_found_in = rd_row_ff.slot[hit_slot].data;
                  end else begin
                     wr_en = 1'b1;
                     wr_row.valid[hit_slot] = 1'b0;
                     if (hit_slot == '0) begin
                        free_in = free_ff + CFG_W'(1);
                     end
                  end
               end
            end
            state_in = accept ? ST_HASH : ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      if (csr_valid) begin
         eff_in      = eff_of(csr_bucket_count);
         used_in     = '0;
         coll_in     = '0;
         full_in     = '0;
         free_in     = eff_of(csr_bucket_count);
         clr_addr_in = '0;
         state_in    = ST_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
      if (rd_en) begin
         rd_row_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      len_ff        <= len_in;
      data_ff       <= data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_slot_ff   <= rsp_slot_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         eff_ff       <= eff_of(CFG_W'(BUCKET_COUNT_RESET));
         used_ff      <= '0;
         coll_ff      <= '0;
         full_ff      <= '0;
         free_ff      <= eff_of(CFG_W'(BUCKET_COUNT_RESET));
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         eff_ff       <= eff_in;
         used_ff      <= used_in;
         coll_ff      <= coll_in;
         full_ff      <= full_in;
         free_ff      <= free_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = rsp_status_ff;
   assign rsp_found_data         = rsp_found_ff;
   assign rsp_bucket_index       = rsp_index_ff;
   assign rsp_slot_number        = rsp_slot_ff;
   assign rsp_used_buckets       = used_ff;
   assign rsp_collision_count    = coll_ff;
   assign rsp_full_bucket_count  = full_ff;
   assign rsp_empty_bucket_count = free_ff;

endmodule
`default_nettype wire

[src/bht_checker.sv]
// Port-level assertions for the bucketed hash table and their bind.
`default_nettype none
module bht_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic        rsp_status,
   input wire logic [31:0] rsp_found_data,
   input wire logic [1:0]  rsp_slot_number
);

   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after a request was taken");

   a_result_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##5 rsp_valid)
      else $error("result did not appear five cycles after the request");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");

   a_miss_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_slot_number == 2'd0 && rsp_found_data == 32'd0))
      else $error("a failed request reported a slot or payload");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_slot_number != 2'd3)
      else $error("slot number out of range");

endmodule

bind bucketed_hash_table_unit bht_checker u_bht_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_found_data  (rsp_found_data),
   .rsp_slot_number (rsp_slot_number)
);
`default_nettype wire
